### rtl/core/i2crm_pkg.sv
package i2crm_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_BUS = 1'd1;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
  localparam logic [7:0] SECOND_BUS_RST = 8'hea;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 16;

  // Packed so that the last field sits in the lowest bits.
  typedef struct packed {
    logic [4:0] pad;
    logic       bus1_sda_in;
    logic       bus0_sda_in;
    logic [7:0] write_value;
    logic [7:0] register_address;
    logic [7:0] device_address;
    logic       request_valid;
  } in_data_t;

  typedef struct packed {
    logic     command;
    in_data_t data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       done_res;
    logic       busy_res;
    logic       bus1_sda_drive;
    logic       bus1_sda;
    logic       bus1_scl;
    logic       bus0_sda_drive;
    logic       bus0_sda;
    logic       bus0_scl;
  } res_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  second_bus_address;
  } cfg_t;

endpackage

### rtl/core/i2crm_engine.sv
module i2crm_engine
  import i2crm_pkg::*;
#(
  parameter int PHASE_COUNT_WIDTH = 16,
  parameter int POST_ACK_PHASES = 10
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  localparam int CNT_W = PHASE_COUNT_WIDTH + $clog2(POST_ACK_PHASES + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_START_A, ST_START_B, ST_START_C, ST_WB_LOW, ST_WB_DATA, ST_WB_HIGH,
    ST_WB_END, ST_ACK_REL, ST_ACK_HIGH, ST_ACK_CHECK, ST_RD_HIGH, ST_RD_SAMPLE,
    ST_STOP_A, ST_STOP_B, ST_STOP_C, ST_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [1:0]       byte_r, byte_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             cmd_r, cmd_nxt;
  logic [7:0]       dev_r, dev_nxt;
  logic [7:0]       reg_r, reg_nxt;
  logic [7:0]       wval_r, wval_nxt;
  logic             bus_r, bus_nxt;
  logic [3:0]       lvl_r, lvl_nxt;
  logic [1:0]       drv_r, drv_nxt;
  logic [7:0]       rdval_r, rdval_nxt;
  res_t             res_r, res_nxt;

  logic [31:0]                  pt_ext;
  logic [PHASE_COUNT_WIDTH-1:0] p_raw;
  logic [CNT_W-1:0]             p_cnt;
  logic [CNT_W-1:0]             p_post;
  logic [CNT_W-1:0]             cnt_dec;
  logic                         act;
  logic                         done_nxt;
  logic [1:0]                   sda_i;
  logic [1:0]                   scl_i;
  logic                         sda_sel;
  logic [7:0]                   rd_shift;

  function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic cmd,
                                          input logic [7:0] dev, input logic [7:0] rga,
                                          input logic [7:0] wv);
    logic [7:0] b;
    case (idx)
      2'd0: b = dev;
      2'd1: b = rga;
      2'd2: b = (cmd == CMD_READ) ? (dev | 8'h01) : wv;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  assign pt_ext = 32'(cfg.phase_ticks);
  assign p_raw = pt_ext[PHASE_COUNT_WIDTH-1:0];
  assign p_cnt = (p_raw == '0) ? CNT_W'(1) : CNT_W'(p_raw);
  assign p_post = p_cnt * CNT_W'(POST_ACK_PHASES);
  assign cnt_dec = (cnt_r != '0) ? (cnt_r - CNT_W'(1)) : cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    bit_nxt = bit_r;
    byte_nxt = byte_r;
    shift_nxt = shift_r;
    cmd_nxt = cmd_r;
    dev_nxt = dev_r;
    reg_nxt = reg_r;
    wval_nxt = wval_r;
    bus_nxt = bus_r;
    lvl_nxt = lvl_r;
    drv_nxt = drv_r;
    rdval_nxt = rdval_r;
    done_nxt = 1'b0;
    act = 1'b0;

    if (state_r == ST_IDLE) begin
      if (item.data.request_valid) begin
        cmd_nxt = item.command;
        dev_nxt = item.data.device_address;
        reg_nxt = item.data.register_address;
        wval_nxt = item.data.write_value;
        bus_nxt = (item.data.device_address == cfg.second_bus_address);
        byte_nxt = 2'd0;
        state_nxt = ST_START_A;
        act = 1'b1;
      end
    end else begin
      cnt_nxt = cnt_dec;
      act = (cnt_dec == '0);
    end

    sda_i = {bus_nxt, 1'b0};
    scl_i = {bus_nxt, 1'b1};
    sda_sel = bus_nxt ? item.data.bus1_sda_in : item.data.bus0_sda_in;
    rd_shift = {shift_r[6:0], sda_sel};

    if (act) begin
      cnt_nxt = p_cnt;
      case (state_nxt)
        ST_START_A: begin
          lvl_nxt[sda_i] = 1'b1;
          lvl_nxt[scl_i] = 1'b1;
          drv_nxt[bus_nxt] = 1'b1;
          state_nxt = ST_START_B;
        end
        ST_START_B: begin
          lvl_nxt[sda_i] = 1'b1;
          state_nxt = ST_START_C;
        end
        ST_START_C: begin
          lvl_nxt[sda_i] = 1'b0;
          bit_nxt = 3'd7;
          shift_nxt = byte_for(byte_nxt, cmd_nxt, dev_nxt, reg_nxt, wval_nxt);
          state_nxt = ST_WB_LOW;
        end
        ST_WB_LOW: begin
          drv_nxt[bus_nxt] = 1'b1;
          lvl_nxt[scl_i] = 1'b0;
          state_nxt = ST_WB_DATA;
        end
        ST_WB_DATA: begin
          lvl_nxt[sda_i] = shift_r[bit_r];
          state_nxt = ST_WB_HIGH;
        end
        ST_WB_HIGH: begin
          lvl_nxt[scl_i] = 1'b1;
          if (bit_r == 3'd0) begin
            state_nxt = ST_WB_END;
          end else begin
            bit_nxt = bit_r - 3'd1;
            state_nxt = ST_WB_LOW;
          end
        end
        ST_WB_END: begin
          lvl_nxt[scl_i] = 1'b0;
          state_nxt = ST_ACK_REL;
        end
        ST_ACK_REL: begin
          drv_nxt[bus_nxt] = 1'b0;
          state_nxt = ST_ACK_HIGH;
        end
        ST_ACK_HIGH: begin
          lvl_nxt[scl_i] = 1'b1;
          state_nxt = ST_ACK_CHECK;
        end
        ST_ACK_CHECK: begin
          if (!sda_sel) begin
            lvl_nxt[scl_i] = 1'b0;
            cnt_nxt = p_post;
            if (byte_r >= 2'd2) begin
              if (cmd_r == CMD_READ) begin
                shift_nxt = 8'h00;
                bit_nxt = 3'd7;
                state_nxt = ST_RD_HIGH;
              end else begin
                state_nxt = ST_STOP_A;
              end
            end else if (cmd_r == CMD_READ && byte_r == 2'd1) begin
              byte_nxt = 2'd2;
              state_nxt = ST_START_A;
            end else begin
              byte_nxt = byte_r + 2'd1;
              bit_nxt = 3'd7;
              shift_nxt = byte_for(byte_r + 2'd1, cmd_r, dev_r, reg_r, wval_r);
              state_nxt = ST_WB_LOW;
            end
          end
        end
        ST_RD_HIGH: begin
          drv_nxt[bus_nxt] = 1'b0;
          lvl_nxt[scl_i] = 1'b1;
          state_nxt = ST_RD_SAMPLE;
        end
        ST_RD_SAMPLE: begin
          shift_nxt = rd_shift;
          lvl_nxt[scl_i] = 1'b0;
          if (bit_r == 3'd0) begin
            rdval_nxt = rd_shift;
            state_nxt = ST_STOP_A;
          end else begin
            bit_nxt = bit_r - 3'd1;
            state_nxt = ST_RD_HIGH;
          end
        end
        ST_STOP_A: begin
          drv_nxt[bus_nxt] = 1'b1;
          lvl_nxt[scl_i] = 1'b1;
          state_nxt = ST_STOP_B;
        end
        ST_STOP_B: begin
          lvl_nxt[sda_i] = 1'b0;
          state_nxt = ST_STOP_C;
        end
        ST_STOP_C: begin
          lvl_nxt[sda_i] = 1'b1;
          state_nxt = ST_FINISH;
        end
        default: begin
          cnt_nxt = '0;
          state_nxt = ST_IDLE;
          done_nxt = 1'b1;
        end
      endcase
    end

    res_nxt.bus0_scl = lvl_nxt[1];
    res_nxt.bus0_sda = lvl_nxt[0];
    res_nxt.bus0_sda_drive = drv_nxt[0];
    res_nxt.bus1_scl = lvl_nxt[3];
    res_nxt.bus1_sda = lvl_nxt[2];
    res_nxt.bus1_sda_drive = drv_nxt[1];
    res_nxt.busy_res = (state_nxt != ST_IDLE);
    res_nxt.done_res = done_nxt;
    res_nxt.read_value = rdval_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      bit_r <= 3'd7;
      byte_r <= 2'd0;
      shift_r <= 8'h00;
      cmd_r <= 1'b0;
      dev_r <= 8'h00;
      reg_r <= 8'h00;
      wval_r <= 8'h00;
      bus_r <= 1'b0;
      lvl_r <= 4'h0;
      drv_r <= 2'b00;
      rdval_r <= 8'h00;
    end else if (step) begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      bit_r <= bit_nxt;
      byte_r <= byte_nxt;
      shift_r <= shift_nxt;
      cmd_r <= cmd_nxt;
      dev_r <= dev_nxt;
      reg_r <= reg_nxt;
      wval_r <= wval_nxt;
      bus_r <= bus_nxt;
      lvl_r <= lvl_nxt;
      drv_r <= drv_nxt;
      rdval_r <= rdval_nxt;
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

### rtl/core/i2c_register_master_top.sv
// Channel | Direction | Ports                          | Contents
// in      | slave     | in_tvalid in_tready in_tdata   | one timing tick with optional request
//         |           | in_tuser                       | command (0 write, 1 read)
// out     | master    | out_tvalid out_tready out_tdata| pin levels, status, read byte
// cfg     | write     | cfg_we cfg_addr cfg_wdata      | phase_ticks, second_bus_address
//
// One item is accepted per cycle while the result is not stalled; each item passes through
// the input register and then the result register, which sit around the tick logic.
// Reset is synchronous and active low; the bus engine comes up idle with its levels low.
// A stalled result holds the result register and backs up through the input register.
module i2c_register_master_top
  import i2crm_pkg::*;
#(
  parameter int PHASE_COUNT_WIDTH = 16,
  parameter int POST_ACK_PHASES = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // request_valid, device_address, register_address, write_value, bus0_sda_in,
  // bus1_sda_in, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // bus0_scl, bus0_sda, bus0_sda_drive, bus1_scl, bus1_sda, bus1_sda_drive,
  // busy_res, done_res, read_value
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic  s1_valid_r;
  item_t s1_item_r;
  logic  out_valid_r;
  logic  step;
  logic  in_acc;
  cfg_t  cfg_r;
  res_t  res;

  assign step = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || step;
  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r.phase_ticks <= PHASE_TICKS_RST;
      cfg_r.second_bus_address <= SECOND_BUS_RST;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PHASE_TICKS: cfg_r.phase_ticks <= cfg_wdata;
          CFG_SECOND_BUS: cfg_r.second_bus_address <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    if (in_acc) begin
      s1_item_r.command <= in_tuser;
      s1_item_r.data <= in_data_t'(in_tdata);
    end
  end

  i2crm_engine #(
    .PHASE_COUNT_WIDTH(PHASE_COUNT_WIDTH),
    .POST_ACK_PHASES(POST_ACK_PHASES)
  ) u_engine (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .item (s1_item_r),
    .cfg  (cfg_r),
    .res  (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata = res;

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_tvalid)
    else $error("processed item did not produce a result");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !step) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input register lost a waiting item");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.done_res) |-> !res.busy_res)
    else $error("done reported while still busy");

endmodule
